>>> rtl/core/rde_pkg.sv
package rde_pkg;

  typedef enum logic [1:0] {
    REG_NUM_COLS   = 2'd0,
    REG_REFRESH    = 2'd1,
    REG_LEVEL2_MAX = 2'd2,
    REG_LEVEL3_MAX = 2'd3
  } reg_idx_t;

  localparam logic [7:0] MARK2     = 8'b1100_0000;
  localparam logic [7:0] MARK3     = 8'b1110_0000;
  localparam logic [7:0] FALL_MASK = 8'b1011_1111;
  localparam logic [7:0] RAW_MASK  = 8'b0111_1111;

  localparam logic [4:0]  NUM_COLS_RST = 5'd1;
  localparam logic [15:0] REFRESH_RST  = 16'd0;
  localparam logic [12:0] LEVEL2_RST   = 13'd8191;
  localparam logic [20:0] LEVEL3_RST   = 21'd2097151;

  localparam logic [2:0] BYTES_L2  = 3'd2;
  localparam logic [2:0] BYTES_L3  = 3'd3;
  localparam logic [2:0] BYTES_RAW = 3'd4;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
  } enc_t;

endpackage

>>> rtl/core/row_delta_encoder.sv
// Row delta encoder. Column values arrive one per request on the in_ channel;
// each column is emitted as 2, 3 or 4 bytes, most significant first, on the
// out_ channel with tuser marking a column's last byte and tlast a row's last
// byte. Each byte of a column is one transfer on the out_ channel, and a new
// column is taken while the previous one still drains. The request's value and
// the last-value memory read are registered in stage 1; from there the column
// loads the output buffer when the previous column's last byte has left the
// output buffer. Write configuration only while the block is idle.
module row_delta_encoder #(
  parameter int MAX_COLS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] col_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tuser,  // [0] col_end
  output logic        out_tlast
);

  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNW = $clog2(MAX_COLS + 1);
  localparam int EW  = (CNW > 5) ? CNW : 5;

  logic [4:0]  num_cols_r;
  logic [15:0] refresh_r;
  logic [12:0] level2_r;
  logic [20:0] level3_r;

  logic [CW-1:0] col_index_r;
  logic [15:0]   rsr_r;
  logic          has_origin_r;
  logic          row_is_raw_r;

  logic [31:0] mem [MAX_COLS];
  logic [31:0] prev_r;

  logic        s1_v_r;
  logic [31:0] s1_cur_r;
  logic        s1_raw_r;
  logic        s1_last_r;

  logic [3:0][7:0] ob_r;
  logic [2:0]      ob_cnt_r;
  logic            ob_last_r;

  logic          in_acc;
  logic          out_acc;
  logic          load;
  logic [EW-1:0] ncols;
  logic [EW-1:0] colp1;
  logic          last_col;
  logic          raw_now;
  rde_pkg::enc_t enc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r <= rde_pkg::NUM_COLS_RST;
      refresh_r  <= rde_pkg::REFRESH_RST;
      level2_r   <= rde_pkg::LEVEL2_RST;
      level3_r   <= rde_pkg::LEVEL3_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rde_pkg::REG_NUM_COLS:   num_cols_r <= cfg_wdata[4:0];
        rde_pkg::REG_REFRESH:    refresh_r  <= cfg_wdata[15:0];
        rde_pkg::REG_LEVEL2_MAX: level2_r   <= cfg_wdata[12:0];
        rde_pkg::REG_LEVEL3_MAX: level3_r   <= cfg_wdata[20:0];
        default: ;
      endcase
    end
  end

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign load    = s1_v_r && (ob_cnt_r == 3'd0 || (ob_cnt_r == 3'd1 && out_tready));
  assign in_tready = !s1_v_r || load;

  always_comb begin
    ncols = EW'(num_cols_r);
    if (ncols == '0) begin
      ncols = EW'(1);
    end else if (ncols > EW'(MAX_COLS)) begin
      ncols = EW'(MAX_COLS);
    end
  end

  assign colp1    = EW'(col_index_r) + EW'(1);
  assign last_col = colp1 >= ncols;
  assign raw_now  = (col_index_r == '0) ?
                    (!has_origin_r || (refresh_r != '0 && rsr_r >= refresh_r)) :
                    row_is_raw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_index_r  <= '0;
      rsr_r        <= '0;
      has_origin_r <= 1'b0;
      row_is_raw_r <= 1'b0;
    end else if (in_acc) begin
      row_is_raw_r <= raw_now;
      if (last_col) begin
        col_index_r <= '0;
        if (raw_now) begin
          rsr_r        <= '0;
          has_origin_r <= 1'b1;
        end else if (rsr_r != 16'hFFFF) begin
          rsr_r <= rsr_r + 16'd1;
        end
      end else begin
        col_index_r <= colp1[CW-1:0];
      end
    end
  end

  // read old entry and write new value at the same address
  always_ff @(posedge clk) begin
    if (in_acc) begin
      prev_r           <= mem[col_index_r];
      mem[col_index_r] <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (load) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cur_r  <= in_tdata;
      s1_raw_r  <= raw_now;
      s1_last_r <= last_col;
    end
  end

  rde_code u_code (
    .cur        (s1_cur_r),
    .prev       (prev_r),
    .raw        (s1_raw_r),
    .level2_max (level2_r),
    .level3_max (level3_r),
    .enc        (enc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_cnt_r <= 3'd0;
    end else if (load) begin
      ob_cnt_r <= enc.cnt;
    end else if (out_acc) begin
      ob_cnt_r <= ob_cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ob_r      <= enc.bytes;
      ob_last_r <= s1_last_r;
    end else if (out_acc) begin
      ob_r <= {8'h00, ob_r[3:1]};
    end
  end

  assign out_tvalid = ob_cnt_r != 3'd0;
  assign out_tdata  = ob_r[0];
  assign out_tuser  = ob_cnt_r == 3'd1;
  assign out_tlast  = ob_cnt_r == 3'd1 && ob_last_r;

  a_row_end_on_col_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("row end without column end");

  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && last_col |=> col_index_r == '0)
    else $error("column index did not wrap at row end");

  a_rows_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(rsr_r))
    else $error("row counter moved without a request");

  a_load_ok: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> ob_cnt_r >= rde_pkg::BYTES_L2 && ob_cnt_r <= rde_pkg::BYTES_RAW)
    else $error("bad byte count loaded");

endmodule

>>> rtl/core/rde_code.sv
module rde_code (
  input  logic [31:0]   cur,
  input  logic [31:0]   prev,
  input  logic          raw,
  input  logic [12:0]   level2_max,
  input  logic [20:0]   level3_max,
  output rde_pkg::enc_t enc
);

  logic [32:0] diff;
  logic        falling;
  logic [31:0] d;
  logic [7:0]  b1_l2;
  logic [7:0]  b1_l3;

  assign diff    = {1'b0, cur} - {1'b0, prev};
  assign falling = diff[32];
  assign d       = falling ? (32'd0 - diff[31:0]) : diff[31:0];

  always_comb begin
    b1_l2 = rde_pkg::MARK2 | {3'b000, d[12:8]};
    b1_l3 = rde_pkg::MARK3 | {3'b000, d[20:16]};
    if (falling) begin
      b1_l2 = b1_l2 & rde_pkg::FALL_MASK;
      b1_l3 = b1_l3 & rde_pkg::FALL_MASK;
    end
    if (!raw && d <= {19'd0, level2_max}) begin
      enc.bytes = {8'h00, 8'h00, d[7:0], b1_l2};
      enc.cnt   = rde_pkg::BYTES_L2;
    end else if (!raw && d <= {11'd0, level3_max}) begin
      enc.bytes = {8'h00, d[7:0], d[15:8], b1_l3};
      enc.cnt   = rde_pkg::BYTES_L3;
    end else begin
      enc.bytes = {cur[7:0], cur[15:8], cur[23:16], cur[31:24] & rde_pkg::RAW_MASK};
      enc.cnt   = rde_pkg::BYTES_RAW;
    end
  end

endmodule

>>> dv/tb_row_delta_encoder.sv
`timescale 1ns / 1ps

module tb_row_delta_encoder;

  localparam int COLS_MAX = 16;

  typedef struct packed {
    logic [7:0] data;
    logic       col_end;
    logic       row_end;
  } enc_byte_t;

  class enc_scoreboard;
    logic [4:0]  num_cols;
    logic [15:0] refresh;
    logic [12:0] lvl2;
    logic [20:0] lvl3;
    logic [31:0] last_val [COLS_MAX];
    int unsigned col_idx;
    logic [15:0] rows_since_raw;
    bit          has_origin;
    bit          row_raw;
    enc_byte_t   expected_bytes[$];
    int          errors;
    int          checked;
    int          cols;
    int          writes;

    function new();
      num_cols       = rde_pkg::NUM_COLS_RST;
      refresh        = rde_pkg::REFRESH_RST;
      lvl2           = rde_pkg::LEVEL2_RST;
      lvl3           = rde_pkg::LEVEL3_RST;
      col_idx        = 0;
      rows_since_raw = '0;
      has_origin     = 1'b0;
      row_raw        = 1'b0;
      errors         = 0;
      checked        = 0;
      cols           = 0;
      writes         = 0;
      for (int i = 0; i < COLS_MAX; i++) last_val[i] = '0;
    endfunction

    function void set_reg(rde_pkg::reg_idx_t idx, logic [20:0] v);
      writes++;
      case (idx)
        rde_pkg::REG_NUM_COLS:   num_cols = v[4:0];
        rde_pkg::REG_REFRESH:    refresh  = v[15:0];
        rde_pkg::REG_LEVEL2_MAX: lvl2     = v[12:0];
        rde_pkg::REG_LEVEL3_MAX: lvl3     = v[20:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void note_column(logic [31:0] v);
      int unsigned eff;
      int unsigned n;
      logic [31:0] prev;
      logic [31:0] d;
      logic [7:0]  enc [4];
      bit          rising;
      bit          last_col;
      enc_byte_t   e;
      cols++;
      eff = (num_cols == 0) ? 1 : ((num_cols > COLS_MAX) ? COLS_MAX : num_cols);
      if (col_idx == 0)
        row_raw = !has_origin || (refresh != 0 && rows_since_raw >= refresh);
      prev   = last_val[col_idx];
      rising = v >= prev;
      d      = rising ? v - prev : prev - v;
      if (!row_raw && d <= {19'd0, lvl2}) begin
        enc[0] = rde_pkg::MARK2 | {3'b000, d[12:8]};
        enc[1] = d[7:0];
        n = 2;
      end else if (!row_raw && d <= {11'd0, lvl3}) begin
        enc[0] = rde_pkg::MARK3 | {3'b000, d[20:16]};
        enc[1] = d[15:8];
        enc[2] = d[7:0];
        n = 3;
      end else begin
        enc[0] = v[31:24] & rde_pkg::RAW_MASK;
        enc[1] = v[23:16];
        enc[2] = v[15:8];
        enc[3] = v[7:0];
        n = 4;
      end
      if (n < 4 && !rising) enc[0] = enc[0] & rde_pkg::FALL_MASK;
      last_col = (col_idx + 1) >= eff;
      for (int i = 0; i < n; i++) begin
        e.data    = enc[i];
        e.col_end = (i == n - 1);
        e.row_end = (i == n - 1) && last_col;
        expected_bytes.push_back(e);
      end
      last_val[col_idx] = v;
      if (last_col) begin
        col_idx = 0;
        if (row_raw) begin
          rows_since_raw = '0;
          has_origin     = 1'b1;
        end else if (rows_since_raw != 16'hFFFF) begin
          rows_since_raw++;
        end
      end else begin
        col_idx++;
      end
    endfunction

    function void check_byte(logic [7:0] data, logic col_end, logic row_end);
      enc_byte_t e;
      checked++;
      if (expected_bytes.size() == 0) begin
        if (errors < 10)
          $display("mismatch: unexpected byte %02h col_end %0b row_end %0b",
                   data, col_end, row_end);
        errors++;
        return;
      end
      e = expected_bytes.pop_front();
      if (e.data !== data || e.col_end !== col_end || e.row_end !== row_end) begin
        if (errors < 10)
          $display("mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                   e.data, e.col_end, e.row_end, data, col_end, row_end);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [20:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;

  enc_scoreboard sb = new();

  row_delta_encoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
    if (rst_n && out_tvalid && out_tready)
      sb.check_byte(out_tdata, out_tuser, out_tlast);
  end

  task automatic cfg_write(input rde_pkg::reg_idx_t idx, input logic [20:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic send_column(input logic [31:0] v);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_column(v);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // pick most values around the column's last value, some at the level boundaries
  function automatic logic [31:0] next_value();
    logic [31:0] prev;
    logic [31:0] d;
    bit          down;
    prev = sb.last_val[sb.col_idx];
    down = 1'($urandom_range(1));
    case ($urandom_range(9))
      0: return $urandom;
      1: d = 32'd0;
      2: d = $urandom_range(sb.lvl2);
      3: d = 32'(sb.lvl2) + $urandom_range(1);
      4: d = $urandom_range(sb.lvl3, 32'(sb.lvl2) + 32'd1);
      5: d = 32'(sb.lvl3) + $urandom_range(1);
      6: return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
      7: d = 32'h0020_0000 + $urandom_range(1000);
      default: d = $urandom_range(255);
    endcase
    return down ? prev - d : prev + d;
  endfunction

  task automatic run_phase(input logic [4:0] nc, input logic [15:0] rf,
                           input logic [12:0] l2, input logic [20:0] l3,
                           input int unsigned idle, input int unsigned stall,
                           input int count);
    wait_idle();
    cfg_write(rde_pkg::REG_NUM_COLS, {16'd0, nc});
    cfg_write(rde_pkg::REG_REFRESH, {5'd0, rf});
    cfg_write(rde_pkg::REG_LEVEL2_MAX, {8'd0, l2});
    cfg_write(rde_pkg::REG_LEVEL3_MAX, l3);
    in_idle_pct   = idle;
    out_stall_pct = stall;
    repeat (count) send_column(next_value());
    in_tvalid <= 1'b0;
  endtask

  initial begin
    logic [31:0] raw_row [16];
    logic [31:0] delta_row [8];
    raw_row = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h0000_0001, 32'hFFFF_0000, 32'h0000_FFFF, 32'hA5A5_A5A5,
                32'h5A5A_5A5A, 32'h1234_5678, 32'h00FF_00FF, 32'hFF00_FF00,
                32'h7FFF_FFFE, 32'h8000_0001, 32'hDEAD_BEEF, 32'h0F0F_0F0F};
    delta_row = '{32'h0000_0000, 32'hFFFF_E000, 32'h8000_2000, 32'h7FE0_0000,
                  32'h0020_0000, 32'hFFDF_0000, 32'h0020_FFFF, 32'hA5A5_A5A4};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every column with a raw row first
    cfg_write(rde_pkg::REG_NUM_COLS, 21'd16);
    foreach (raw_row[i]) send_column(raw_row[i]);
    wait_idle();
    cfg_write(rde_pkg::REG_NUM_COLS, 21'd8);
    foreach (delta_row[i]) send_column(delta_row[i]);

    run_phase(5'd4,  16'd3,     13'd8191, 21'd2097151, 0,  0,  30);
    run_phase(5'd3,  16'd1,     13'd100,  21'd5000,    73, 0,  30);
    run_phase(5'd0,  16'd0,     13'd0,    21'd0,       0,  73, 30);
    run_phase(5'd31, 16'd2,     13'd8191, 21'd300,     30, 30, 30);
    run_phase(5'd5,  16'd65535, 13'd4000, 21'd2097151, 73, 73, 30);

    wait_idle();
    repeat (8) @(posedge clk);
    $display("covered %0d column requests and %0d register writes", sb.cols, sb.writes);
    $display("checked %0d bytes, %0d mismatches, %0d bytes outstanding",
             sb.checked, sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout: encoder stopped making progress");
    $display("status: fail");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/rde_pkg.sv
rtl/core/rde_code.sv
rtl/core/row_delta_encoder.sv
dv/tb_row_delta_encoder.sv
